// ----- hdl/iidl_pkg.sv -----
package iidl_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    REQ_READ     = 3'd0,
    REQ_INS_HEAD = 3'd1,
    REQ_INS_TAIL = 3'd2,
    REQ_INS_POS  = 3'd3,
    REQ_DELETE   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [CMP_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ----- hdl/indexed_insert_delete_list.sv -----
// Ordered list of up to 64 signed 32-bit values held in a row of cells that
// shift together: an insert moves every later element up one place and a
// delete moves them down one place, all in the cycle of the transaction. One
// transaction is accepted per clock (busy stays low), and its result is
// registered onto the out_ ports, marked by out_valid for exactly one
// cycle. The receiver cannot stall, so it must take every result as it comes.
// out_length reports the element count after the transaction; bad positions
// and inserts into a full list change nothing and report a status instead.
module indexed_insert_delete_list (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_req_type,
  input  logic [iidl_pkg::POS_W-1:0]    in_position,
  input  logic signed [iidl_pkg::VAL_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [iidl_pkg::VAL_W-1:0] out_read_value,
  output logic [1:0]                    out_status,
  output logic [iidl_pkg::LEN_W-1:0]    out_length
);
  import iidl_pkg::*;

  logic             accept;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] ins_pos;
  logic             is_ins;
  logic             is_rd;
  status_t          status;
  cell_ctl_t        ctl;
  logic [VAL_W-1:0] rd_or;
  logic [CMP_W-1:0] len_nxt_ext;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic [1:0]       out_status_r;
  logic [LEN_W-1:0] out_length_r;

  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [VAL_W-1:0] cell_rd  [CAPACITY];

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign count_ext = CMP_W'(count_r);
  assign pos_ext   = CMP_W'(in_position);

  // decode the request and check position and fullness
  always_comb begin
    is_ins    = 1'b0;
    is_rd     = 1'b0;
    ins_pos   = pos_ext;
    status    = ST_DONE;
    ctl.ins   = 1'b0;
    ctl.del   = 1'b0;
    ctl.pos   = pos_ext;
    count_nxt = count_r;
    case (req_t'(in_req_type))
      REQ_READ: begin
        is_rd = 1'b1;
        if (pos_ext >= count_ext) begin
          status = ST_BADPOS;
        end
      end
      REQ_INS_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      REQ_INS_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = count_ext;
      end
      REQ_INS_POS: begin
        is_ins = 1'b1;
      end
      REQ_DELETE: begin
        if (pos_ext >= count_ext) begin
          status = ST_BADPOS;
        end else begin
          ctl.del   = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (is_ins) begin
      ctl.pos = ins_pos;
      if (ins_pos > count_ext) begin
        status = ST_BADPOS;
      end else if (count_ext == CMP_W'(CAPACITY)) begin
        status = ST_FULL;
      end else begin
        ctl.ins   = accept;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // row of cells
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [VAL_W-1:0] left_v;
      logic [VAL_W-1:0] right_v;
      if (gi == 0) begin : g_first
        assign left_v = '0;
      end else begin : g_mid_l
        assign left_v = cell_val[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_v = '0;
      end else begin : g_mid_r
        assign right_v = cell_val[gi+1];
      end
      iidl_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .idx       (CMP_W'(gi)),
        .ins_val   (in_value),
        .left_val  (left_v),
        .right_val (right_v),
        .val       (cell_val[gi]),
        .rd_val    (cell_rd[gi])
      );
    end
  endgenerate

  // read bus: only the addressed cell drives a nonzero value
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign len_nxt_ext = CMP_W'(count_nxt);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r <= (is_rd && status == ST_DONE) ? rd_or : '0;
      out_status_r     <= status;
      out_length_r     <= len_nxt_ext[LEN_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_length     = out_length_r;

endmodule

// ----- hdl/iidl_cell.sv -----
module iidl_cell (
  input  logic                      clk,
  input  iidl_pkg::cell_ctl_t       ctl,
  input  logic [iidl_pkg::CMP_W-1:0] idx,
  input  logic [iidl_pkg::VAL_W-1:0] ins_val,
  input  logic [iidl_pkg::VAL_W-1:0] left_val,
  input  logic [iidl_pkg::VAL_W-1:0] right_val,
  output logic [iidl_pkg::VAL_W-1:0] val,
  output logic [iidl_pkg::VAL_W-1:0] rd_val
);
  import iidl_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  // insert moves the lower neighbor up, delete pulls the upper neighbor down
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (idx > ctl.pos) begin
        val_nxt = left_val;
      end else if (idx == ctl.pos) begin
        val_nxt = ins_val;
      end
    end else if (ctl.del) begin
      if (idx >= ctl.pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  // contribution to the read bus
  assign rd_val = (idx == ctl.pos) ? val_r : '0;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import iidl_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int MAX_GAP      = 11;

  typedef enum int {
    MODE_FILL,
    MODE_MIX,
    MODE_DRAIN
  } traffic_mode_t;

  // one expected list response
  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    status_t                 status;
    logic [LEN_W-1:0]        length;
  } list_result_t;

  // tracks the ordered list contents and the responses still owed by the block
  class list_scoreboard_t;
    logic signed [VAL_W-1:0] elems [CAPACITY];
    int unsigned             elem_count;
    list_result_t            expected_q [$];
    int                      errors;
    int                      result_num;

    function new();
      elem_count = 0;
      errors     = 0;
      result_num = 0;
    endfunction

    function status_t insert_at(int unsigned pos, logic signed [VAL_W-1:0] val);
      if (pos > elem_count) return ST_BADPOS;
      if (elem_count >= CAPACITY) return ST_FULL;
      for (int unsigned i = elem_count; i > pos; i--) elems[i] = elems[i-1];
      elems[pos] = val;
      elem_count++;
      return ST_DONE;
    endfunction

    function status_t delete_at(int unsigned pos);
      if (pos >= elem_count) return ST_BADPOS;
      for (int unsigned i = pos; i + 1 < elem_count; i++) elems[i] = elems[i+1];
      elem_count--;
      return ST_DONE;
    endfunction

    // apply an accepted transaction to the list and queue its response
    function void note_input(logic [2:0] req, logic [POS_W-1:0] pos,
                             logic signed [VAL_W-1:0] val);
      list_result_t r;
      r.read_value = '0;
      r.status     = ST_DONE;
      case (req)
        REQ_READ: begin
          if (pos < elem_count) r.read_value = elems[pos];
          else r.status = ST_BADPOS;
        end
        REQ_INS_HEAD: r.status = insert_at(0, val);
        REQ_INS_TAIL: r.status = insert_at(elem_count, val);
        REQ_INS_POS:  r.status = insert_at(pos, val);
        REQ_DELETE:   r.status = delete_at(pos);
        default: ;
      endcase
      r.length = elem_count[LEN_W-1:0];
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, result_num, msg);
      errors++;
    endtask

    // compare one strobed response with the oldest pending one
    task check_result(logic signed [VAL_W-1:0] rd, logic [1:0] st,
                      logic [LEN_W-1:0] len);
      list_result_t exp_r;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("no transaction pending (value %0d status %0d length %0d)",
                                  rd, st, len));
        result_num++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (rd !== exp_r.read_value)
        report_mismatch($sformatf("read_value %0d, expected %0d", rd, exp_r.read_value));
      if (st !== exp_r.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, exp_r.status));
      if (len !== exp_r.length)
        report_mismatch($sformatf("length %0d, expected %0d", len, exp_r.length));
      result_num++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [2:0]              in_req_type = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_read_value;
  logic [1:0]              out_status;
  logic [LEN_W-1:0]        out_length;

  list_scoreboard_t sb = new();
  int               cycle_cnt = 0;

  indexed_insert_delete_list DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_length     (out_length)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (out_valid === 1'b1) sb.check_result(out_read_value, out_status, out_length);
  end

  function automatic int draw_gap(bit no_idle);
    if (no_idle) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // mostly random words, sometimes the corners of the signed range
  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = '1;
        2: v = {1'b1, {(VAL_W-1){1'b0}}};
        default: v = {1'b0, {(VAL_W-1){1'b1}}};
      endcase
    end
    return v;
  endfunction

  // present one transaction after an idle gap and hold it until accepted
  task automatic send_item(input logic [2:0] req, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_input(req, pos, val);
  endtask

  // random transaction, biased by traffic mode and kept mostly in range
  task automatic gen_item(input traffic_mode_t mode, output logic [2:0] req,
                          output logic [POS_W-1:0] pos,
                          output logic signed [VAL_W-1:0] val);
    int          roll;
    int          ins_pct;
    int          del_pct;
    int unsigned cnt;
    roll = $urandom_range(0, 99);
    cnt  = sb.elem_count;
    case (mode)
      MODE_FILL:  begin ins_pct = 80; del_pct = 8;  end
      MODE_DRAIN: begin ins_pct = 8;  del_pct = 80; end
      default:    begin ins_pct = 40; del_pct = 35; end
    endcase
    pos = POS_W'($urandom);
    val = pick_value();
    if (roll < ins_pct) begin
      case ($urandom_range(0, 2))
        0: req = REQ_INS_HEAD;
        1: req = REQ_INS_TAIL;
        default: req = REQ_INS_POS;
      endcase
      if (req == REQ_INS_POS && $urandom_range(0, 99) < 85)
        pos = POS_W'($urandom_range(0, cnt));
    end else if (roll < 97) begin
      req = (roll < ins_pct + del_pct) ? REQ_DELETE : REQ_READ;
      if (cnt > 0 && $urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, cnt - 1));
    end else begin
      // undefined request codes
      req = 3'($urandom_range(5, 7));
    end
  endtask

  initial begin
    logic [2:0]              req;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    traffic_mode_t           mode;
    int                      sent;
    int                      phase;
    int                      phase_len;
    bit                      no_idle;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list misses
    send_item(REQ_READ,    0, 0, draw_gap(0));
    send_item(REQ_DELETE,  0, 0, draw_gap(0));
    send_item(REQ_INS_POS, 1, 5, draw_gap(0));
    // directed: each insert flavor with corner values, ignored position
    send_item(REQ_INS_POS,  0,   32'sh8000_0000, draw_gap(0));
    send_item(REQ_INS_HEAD, 127, 32'sh7fff_ffff, draw_gap(0));
    send_item(REQ_INS_TAIL, 127, -1, draw_gap(0));
    send_item(REQ_INS_TAIL, 0,   0, draw_gap(0));
    send_item(REQ_INS_POS,  4,   32'sh1234_5678, draw_gap(0));
    send_item(REQ_INS_POS,  2,   32'sh0f0f_0f0f, draw_gap(0));
    // read back every element, then past the end
    for (int i = 0; i < 6; i++) send_item(REQ_READ, POS_W'(i), -1, draw_gap(1));
    send_item(REQ_READ,   6,   0, draw_gap(0));
    send_item(REQ_READ,   127, 0, draw_gap(0));
    send_item(REQ_DELETE, 6,   0, draw_gap(0));
    // delete middle, head and tail
    send_item(REQ_DELETE, 2, -1, draw_gap(0));
    send_item(REQ_DELETE, 0, 0,  draw_gap(0));
    send_item(REQ_DELETE, 3, 0,  draw_gap(0));
    // undefined request codes
    for (int i = 5; i < 8; i++) send_item(3'(i), 127, -1, draw_gap(0));
    send_item(REQ_READ, 0, -1, draw_gap(0));

    // random: fill-biased, mix, drain-biased, mix, repeated
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: mode = MODE_FILL;
        2: mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      phase_len = (mode == MODE_MIX) ? $urandom_range(30, 60) : $urandom_range(80, 110);
      no_idle   = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        gen_item(mode, req, pos, val);
        send_item(req, pos, val, draw_gap(no_idle));
        sent++;
      end
      phase++;
    end

    // drop start right at the last accepting edge
    start <= 1'b0;

    // wait for outstanding responses, then watch for stray strobes
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/iidl_pkg.sv
hdl/iidl_cell.sv
hdl/indexed_insert_delete_list.sv
verif/tb_top.sv
